### rtl/core/trpd_pkg.sv
// Shared types, codes and helper functions of the TARGA RLE pixel decoder.
package trpd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned PIXEL_W  = 32;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned COORD_W  = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned BPP_W    = 3;
   localparam int unsigned IDX_W    = 2;
   localparam int unsigned REG_IDX_W = 3;
   localparam int unsigned REG_DATA_W = 16;

   // Command codes of an input word.
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ROW_CROSS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EARLY_END = 2'd2;

   // Configuration register indexes.
   localparam logic [REG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TOP_ORIGIN      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_EXPAND_1555     = 3'd4;

   localparam logic [BPP_W-1:0] BPP_MIN = 3'd2;
   localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

   typedef struct packed {
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic [COORD_W-1:0] image_width;
      logic [COORD_W-1:0] image_height;
      logic               top_origin;
      logic               expand_1555;
   } cfg_type;

   // One decoded packet result as it travels from the parser to the formatter.
   // The row is still counted in decode order here.
   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [COUNT_W-1:0]  count;
      logic [COORD_W-1:0]  column;
      logic [COORD_W-1:0]  decode_row;
      logic                last;
      logic [STATUS_W-1:0] status;
   } entry_type;

   function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] bpp);
      logic [BPP_W-1:0] r;
      r = bpp;
      if (bpp < BPP_MIN) r = BPP_MIN;
      if (bpp > BPP_MAX) r = BPP_MAX;
      return r;
   endfunction

   // Each 5-bit channel becomes {x, x[4:2]}; alpha is all ones or zero.
   function automatic logic [PIXEL_W-1:0] widen_1555(input logic [15:0] px);
      logic [7:0] r8;
      logic [7:0] g8;
      logic [7:0] b8;
      logic [7:0] a8;
      r8 = {px[14:10], px[14:12]};
      g8 = {px[9:5], px[9:7]};
      b8 = {px[4:0], px[4:2]};
      a8 = px[15] ? 8'hff : 8'h00;
      return {a8, r8, g8, b8};
   endfunction

endpackage

### rtl/core/trpd_if.sv
// Handshake channel interfaces of the TARGA RLE pixel decoder.
interface trpd_req_if;
   import trpd_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] data_byte;
   modport source(output valid, output cmd, output data_byte, input ready);
   modport sink(input valid, input cmd, input data_byte, output ready);
endinterface

interface trpd_rsp_if;
   import trpd_pkg::*;
   logic                valid;
   logic                ready;
   logic [PIXEL_W-1:0]  pixel_value;
   logic [COUNT_W-1:0]  repeat_count;
   logic [COORD_W-1:0]  column;
   logic [COORD_W-1:0]  row;
   logic                last_of_image;
   logic [STATUS_W-1:0] status;
   modport source(output valid, output pixel_value, output repeat_count, output column,
                  output row, output last_of_image, output status, input ready);
   modport sink(input valid, input pixel_value, input repeat_count, input column,
                input row, input last_of_image, input status, output ready);
   modport monitor(input valid, input ready, input pixel_value, input repeat_count,
                   input column, input row, input last_of_image, input status);
endinterface

interface trpd_csr_if;
   import trpd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REG_IDX_W-1:0]  reg_index;
   logic [REG_DATA_W-1:0] wdata;
   modport source(output valid, output reg_index, output wdata, input ready);
   modport sink(input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/core/trpd_front.sv
// Stream parser: tracks packets, assembles pixels and positions, flags errors.
module trpd_front (
   input  logic                clock,
   input  logic                reset,
   input  trpd_pkg::cfg_type   cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_cmd,
   input  logic [7:0]          in_byte,
   input  logic                q_full,
   output logic                push,
   output trpd_pkg::entry_type push_entry
);
   import trpd_pkg::*;

   logic                expecting_header_ff, expecting_header_in;
   logic                run_packet_ff, run_packet_in;
   logic [COUNT_W-1:0]  pixels_left_ff, pixels_left_in;
   logic [IDX_W-1:0]    byte_index_ff, byte_index_in;
   logic [PIXEL_W-1:0]  acc_ff, acc_in;
   logic [COORD_W-1:0]  column_ff, column_in;
   logic [COORD_W-1:0]  row_ff, row_in;

   logic                accept;
   logic                at_start;
   logic [BPP_W-1:0]    bpp;
   logic [COUNT_W-1:0]  hdr_count;
   logic [COORD_W:0]    hdr_end;
   logic [PIXEL_W-1:0]  acc_next;
   logic [COUNT_W-1:0]  px_count;
   logic [COUNT_W-1:0]  left_next;
   logic [COORD_W:0]    col_next;
   logic [COORD_W:0]    row_next;
   logic                last;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign bpp      = eff_bpp(cfg.bytes_per_pixel);
   assign at_start = expecting_header_ff && (byte_index_ff == '0) &&
                     (column_ff == '0) && (row_ff == '0);

   assign hdr_count = {1'b0, in_byte[6:0]} + COUNT_W'(1);
   assign hdr_end   = {1'b0, column_ff} + {{(COORD_W+1-COUNT_W){1'b0}}, hdr_count};
   assign acc_next  = acc_ff | (PIXEL_W'(in_byte) << {byte_index_ff, 3'b000});
   assign px_count  = run_packet_ff ? pixels_left_ff : COUNT_W'(1);
   assign left_next = run_packet_ff ? '0 : pixels_left_ff - COUNT_W'(1);
   assign col_next  = {1'b0, column_ff} + {{(COORD_W+1-COUNT_W){1'b0}}, px_count};
   assign row_next  = {1'b0, row_ff} + (COORD_W+1)'(1);
   assign last      = (col_next >= {1'b0, cfg.image_width}) &&
                      (row_next >= {1'b0, cfg.image_height});

   always_comb begin
      expecting_header_in = expecting_header_ff;
      run_packet_in       = run_packet_ff;
      pixels_left_in      = pixels_left_ff;
      byte_index_in       = byte_index_ff;
      acc_in              = acc_ff;
      column_in           = column_ff;
      row_in              = row_ff;
      push                = 1'b0;
      push_entry          = '0;
      if (accept) begin
         if (in_cmd == CMD_END) begin
            if (!at_start) begin
               push              = 1'b1;
               push_entry.status = STATUS_EARLY_END;
               expecting_header_in = 1'b1;
               run_packet_in       = 1'b0;
               pixels_left_in      = '0;
               byte_index_in       = '0;
               acc_in              = '0;
               column_in           = '0;
               row_in              = '0;
            end
         end else if (expecting_header_ff) begin
            if (hdr_end > {1'b0, cfg.image_width}) begin
               push                = 1'b1;
               push_entry.status   = STATUS_ROW_CROSS;
               run_packet_in       = 1'b0;
               pixels_left_in      = '0;
               byte_index_in       = '0;
               acc_in              = '0;
               column_in           = '0;
               row_in              = '0;
            end else begin
               run_packet_in       = in_byte[7];
               pixels_left_in      = hdr_count;
               expecting_header_in = 1'b0;
               byte_index_in       = '0;
               acc_in              = '0;
            end
         end else if (({1'b0, byte_index_ff} + BPP_W'(1)) < bpp) begin
            byte_index_in = byte_index_ff + IDX_W'(1);
            acc_in        = acc_next;
         end else begin
            // A pixel is complete: report it and advance the position.
            push                  = 1'b1;
            push_entry.pixel      = acc_next;
            push_entry.count      = px_count;
            push_entry.column     = column_ff;
            push_entry.decode_row = row_ff;
            push_entry.last       = last;
            push_entry.status     = STATUS_OK;
            byte_index_in         = '0;
            acc_in                = '0;
            pixels_left_in        = left_next;
            if (left_next == '0) expecting_header_in = 1'b1;
            if (col_next >= {1'b0, cfg.image_width}) begin
               column_in = '0;
               row_in    = row_next[COORD_W-1:0];
            end else begin
               column_in = col_next[COORD_W-1:0];
            end
            if (last) begin
               expecting_header_in = 1'b1;
               run_packet_in       = 1'b0;
               pixels_left_in      = '0;
               column_in           = '0;
               row_in              = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expecting_header_ff <= 1'b1;
         run_packet_ff       <= 1'b0;
         pixels_left_ff      <= '0;
         byte_index_ff       <= '0;
         acc_ff              <= '0;
         column_ff           <= '0;
         row_ff              <= '0;
      end else begin
         expecting_header_ff <= expecting_header_in;
         run_packet_ff       <= run_packet_in;
         pixels_left_ff      <= pixels_left_in;
         byte_index_ff       <= byte_index_in;
         acc_ff              <= acc_in;
         column_ff           <= column_in;
         row_ff              <= row_in;
      end
   end

endmodule

### rtl/core/trpd_queue.sv
// Two-entry queue between the parser and the output formatter.
module trpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  trpd_pkg::entry_type push_entry,
   output logic                full,
   output logic                not_empty,
   input  logic                pop,
   output trpd_pkg::entry_type pop_entry
);
   import trpd_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/core/trpd_back.sv
// Output formatter: 1555 expansion, row origin flip and the result register.
module trpd_back (
   input  logic                clock,
   input  logic                reset,
   input  trpd_pkg::cfg_type   cfg,
   input  logic                q_not_empty,
   output logic                pop,
   input  trpd_pkg::entry_type entry,
   trpd_rsp_if.source          rsp_bus
);
   import trpd_pkg::*;

   logic                valid_ff;
   logic [PIXEL_W-1:0]  pixel_ff, pixel_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COORD_W-1:0]  column_ff;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic                last_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                is_ok;

   assign pop   = q_not_empty && (!valid_ff || rsp_bus.ready);
   assign is_ok = (entry.status == STATUS_OK);

   always_comb begin
      pixel_in = entry.pixel;
      if ((eff_bpp(cfg.bytes_per_pixel) == BPP_MIN) && cfg.expand_1555)
         pixel_in = widen_1555(entry.pixel[15:0]);
      row_in = cfg.top_origin ? entry.decode_row
                              : cfg.image_height - COORD_W'(1) - entry.decode_row;
      if (!is_ok) begin
         pixel_in = '0;
         row_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pixel_ff  <= pixel_in;
         count_ff  <= entry.count;
         column_ff <= entry.column;
         row_ff    <= row_in;
         last_ff   <= entry.last;
         status_ff <= entry.status;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.pixel_value   = pixel_ff;
   assign rsp_bus.repeat_count  = count_ff;
   assign rsp_bus.column        = column_ff;
   assign rsp_bus.row           = row_ff;
   assign rsp_bus.last_of_image = last_ff;
   assign rsp_bus.status        = status_ff;

endmodule

### rtl/core/tga_rle_pixel_decoder.sv
// Top level of the TARGA RLE pixel decoder: configuration registers and datapath.
//
// This block decodes the run-length coded pixel stream of a true-color TARGA
// image, one compressed word per clock cycle with no bubbles, so a stream can
// be fed at full rate for as long as the result side keeps taking words. A run
// packet comes out as one result carrying its pixel and repeat count, a literal
// packet as one result per pixel with a repeat count of one, and each result
// carries its column and its row after the origin flip. Header words and all
// but the last byte of a pixel produce no result. A result passes from the
// word that completes it through the queue, which the parser writes at the
// same edge at which it takes the word, and then through the output register
// of the formatter. The parser keeps all packet and position state and
// updates it for every word it takes, which sets the rate of one word per
// cycle while the queue has room. A
// two-word queue between parser and formatter lets the input keep flowing
// while a result waits to be taken. A packet that would run past the end of
// a row, or an end-of-data word in the middle of an image, returns an error
// result with all other fields zero, and decoding restarts at the image
// start. The configuration registers may only be written while no word is in
// flight; they take effect on the next word.
module tga_rle_pixel_decoder (
   input logic         clock,
   input logic         reset,
   trpd_req_if.sink    req_bus,
   trpd_rsp_if.source  rsp_bus,
   trpd_csr_if.sink    csr_bus
);
   import trpd_pkg::*;

   logic [BPP_W-1:0]   bpp_ff;
   logic [COORD_W-1:0] width_ff;
   logic [COORD_W-1:0] height_ff;
   logic               top_origin_ff;
   logic               expand_ff;
   cfg_type            cfg;

   logic               push;
   entry_type          push_entry;
   logic               q_full;
   logic               q_not_empty;
   logic               pop;
   entry_type          pop_entry;

   // Configuration writes are always taken; writes beyond the last register
   // are dropped.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= 3'd3;
         width_ff      <= 16'd1;
         height_ff     <= 16'd1;
         top_origin_ff <= 1'b0;
         expand_ff     <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            REG_BYTES_PER_PIXEL: bpp_ff        <= csr_bus.wdata[BPP_W-1:0];
            REG_IMAGE_WIDTH:     width_ff      <= csr_bus.wdata;
            REG_IMAGE_HEIGHT:    height_ff     <= csr_bus.wdata;
            REG_TOP_ORIGIN:      top_origin_ff <= csr_bus.wdata[0];
            REG_EXPAND_1555:     expand_ff     <= csr_bus.wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.bytes_per_pixel = bpp_ff;
   assign cfg.image_width     = width_ff;
   assign cfg.image_height    = height_ff;
   assign cfg.top_origin      = top_origin_ff;
   assign cfg.expand_1555     = expand_ff;

   // The parser sees every word and decides what, if anything, it yields.
   trpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_cmd     (req_bus.cmd),
      .in_byte    (req_bus.data_byte),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   trpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   // The formatter turns queued entries into output words.
   trpd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (q_not_empty),
      .pop         (pop),
      .entry       (pop_entry),
      .rsp_bus     (rsp_bus)
   );

endmodule

### rtl/core/trpd_checker.sv
// Port-level checks on the result channel of the TARGA RLE pixel decoder.
module trpd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [trpd_pkg::PIXEL_W-1:0]  rsp_pixel_value,
   input logic [trpd_pkg::COUNT_W-1:0]  rsp_repeat_count,
   input logic [trpd_pkg::COORD_W-1:0]  rsp_column,
   input logic [trpd_pkg::COORD_W-1:0]  rsp_row,
   input logic                          rsp_last_of_image,
   input logic [trpd_pkg::STATUS_W-1:0] rsp_status
);
   import trpd_pkg::*;

   // A word that is not taken stays on the channel; its pixel, count and status hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value) &&
         $stable(rsp_repeat_count) && $stable(rsp_status))
      else $error("result word changed while stalled");

   // Error words carry nothing but their status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_pixel_value == '0) && (rsp_repeat_count == '0) &&
         (rsp_column == '0) && (rsp_row == '0) && !rsp_last_of_image)
      else $error("error word with nonzero fields");

   // Good words repeat a pixel between one and 128 times.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OK) |->
         (rsp_repeat_count != '0) && (rsp_repeat_count <= 8'd128))
      else $error("repeat count out of range");

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_pixel_value   (rsp_bus.pixel_value),
   .rsp_repeat_count  (rsp_bus.repeat_count),
   .rsp_column        (rsp_bus.column),
   .rsp_row           (rsp_bus.row),
   .rsp_last_of_image (rsp_bus.last_of_image),
   .rsp_status        (rsp_bus.status)
);

### tb/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench of the TARGA RLE pixel decoder: image streams in, predicted pixel runs out.
module tb_tga_rle_pixel_decoder;
   import trpd_pkg::*;

   // One decoded result as seen on the result channel.
   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel_value;
      logic [COUNT_W-1:0]  repeat_count;
      logic [COORD_W-1:0]  column;
      logic [COORD_W-1:0]  row;
      logic                last_of_image;
      logic [STATUS_W-1:0] status;
   } pixel_result_type;

   // One word of the compressed stream.
   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] data;
   } stream_word_type;

   // Shapes of generated image streams.
   typedef enum int {
      MODE_WELL,
      MODE_EARLY_END,
      MODE_CROSS,
      MODE_CUT,
      MODE_NOISE
   } image_mode_type;

   localparam logic [BYTE_W-1:0] RUN_FLAG = 8'h80;
   localparam int unsigned WORD_GOAL        = 1450;
   localparam int unsigned IDLE_OFF_AT      = 1150;
   localparam int unsigned HOLD_AT          = 500;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned MAX_PRINTED      = 60;

   // Tracks the decoder's packet and position state, predicts each pixel run
   // and compares the observed results against the predictions in order.
   class pixel_run_scoreboard;
      logic [BPP_W-1:0]   bpp_reg;
      logic [COORD_W-1:0] width_reg;
      logic [COORD_W-1:0] height_reg;
      logic               top_reg;
      logic               expand_reg;

      bit                 want_header;
      bit                 in_run;
      int unsigned        left;
      int unsigned        byte_pos;
      logic [31:0]        acc;
      int unsigned        col;
      int unsigned        row;

      pixel_result_type   pending_pixels[$];
      int unsigned        mismatches;

      function new();
         bpp_reg = 3'd3;
         width_reg = 16'd1;
         height_reg = 16'd1;
         top_reg = 1'b0;
         expand_reg = 1'b0;
         mismatches = 0;
         rewind();
      endfunction

      function void rewind();
         want_header = 1'b1;
         in_run = 1'b0;
         left = 0;
         byte_pos = 0;
         acc = '0;
         col = 0;
         row = 0;
      endfunction

      function void write_register(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] v);
         case (idx)
            REG_BYTES_PER_PIXEL: bpp_reg = v[BPP_W-1:0];
            REG_IMAGE_WIDTH: width_reg = v;
            REG_IMAGE_HEIGHT: height_reg = v;
            REG_TOP_ORIGIN: top_reg = v[0];
            REG_EXPAND_1555: expand_reg = v[0];
            default: ;
         endcase
      endfunction

      function int unsigned pixel_bytes();
         if (bpp_reg < BPP_MIN) return BPP_MIN;
         if (bpp_reg > BPP_MAX) return BPP_MAX;
         return bpp_reg;
      endfunction

      // Moves each 5-bit channel to the top of its byte, then refills the low
      // three bits from the channel's top bits.
      function logic [31:0] to_argb(logic [15:0] px);
         logic [31:0] w;
         logic [31:0] c;
         w = {16'b0, px};
         c = ((w & 32'h7c00) << 9) + ((w & 32'h03e0) << 6) + ((w & 32'h001f) << 3);
         c = c + ((c & 32'h00e0e0e0) >> 5);
         if (px[15]) c = c + 32'hff000000;
         return c;
      endfunction

      function void push_error(logic [STATUS_W-1:0] code);
         pixel_result_type e;
         e = '0;
         e.status = code;
         pending_pixels.push_back(e);
         rewind();
      endfunction

      function void decode_word(logic cmd, logic [BYTE_W-1:0] b);
         int unsigned n;
         int unsigned nxt;
         pixel_result_type r;
         logic [31:0] px;
         if (cmd == CMD_END) begin
            if (want_header && byte_pos == 0 && col == 0 && row == 0) return;
            push_error(STATUS_EARLY_END);
            return;
         end
         if (want_header) begin
            n = b[6:0] + 1;
            if (col + n > width_reg) begin
               push_error(STATUS_ROW_CROSS);
               return;
            end
            in_run = b[7];
            left = n;
            want_header = 1'b0;
            byte_pos = 0;
            acc = '0;
            return;
         end
         acc = acc | ({24'b0, b} << (8 * (byte_pos & 3)));
         if (byte_pos + 1 < pixel_bytes()) begin
            byte_pos = (byte_pos + 1) & 3;
            return;
         end
         px = acc;
         if (pixel_bytes() == 2 && expand_reg) px = to_argb(acc[15:0]);
         byte_pos = 0;
         acc = '0;
         if (in_run) begin
            n = left;
            left = 0;
         end else begin
            n = 1;
            left = (left - 1) & 8'hff;
         end
         if (left == 0) want_header = 1'b1;
         r.pixel_value = px;
         r.repeat_count = n[COUNT_W-1:0];
         r.column = col[COORD_W-1:0];
         r.row = top_reg ? row[COORD_W-1:0] : COORD_W'(32'(height_reg) - 1 - row);
         r.last_of_image = 1'b0;
         r.status = STATUS_OK;
         nxt = col + n;
         if (nxt >= width_reg) begin
            col = 0;
            row = row + 1;
            if (row >= height_reg) r.last_of_image = 1'b1;
            row = row & 32'hffff;
         end else begin
            col = nxt & 32'hffff;
         end
         pending_pixels.push_back(r);
         if (r.last_of_image) rewind();
      endfunction

      task report(string msg);
         if (mismatches < MAX_PRINTED) $display("%0t ns mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_pixel(pixel_result_type got);
         pixel_result_type want;
         if (pending_pixels.size() == 0) begin
            report($sformatf("result with nothing pending (pixel %h status %0d)",
                             got.pixel_value, got.status));
            return;
         end
         want = pending_pixels.pop_front();
         if (got.pixel_value !== want.pixel_value)
            report($sformatf("pixel_value %h, want %h", got.pixel_value, want.pixel_value));
         if (got.repeat_count !== want.repeat_count)
            report($sformatf("repeat_count %0d, want %0d", got.repeat_count, want.repeat_count));
         if (got.column !== want.column)
            report($sformatf("column %0d, want %0d", got.column, want.column));
         if (got.row !== want.row)
            report($sformatf("row %0d, want %0d", got.row, want.row));
         if (got.last_of_image !== want.last_of_image)
            report($sformatf("last_of_image %b, want %b", got.last_of_image,
                             want.last_of_image));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   trpd_req_if req_bus ();
   trpd_rsp_if rsp_bus ();
   trpd_csr_if csr_bus ();

   tga_rle_pixel_decoder u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pixel_run_scoreboard sb;
   stream_word_type     stream_q[$];
   int unsigned         words_sent;
   bit                  send_idling;
   bit                  take_idling;
   bit                  long_hold_req;

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard limit on the run. The slowest legal run (every word behind a full
   // sender gap and a full receiver stall, plus the long hold) stays far
   // below this.
   initial begin
      #20_000_000;
      $display("tb_tga_rle_pixel_decoder NOT OK");
      $finish;
   end

   // Result side. Every accepted word is checked against the oldest
   // prediction. The ready line idles in random bursts, and once during the
   // run it is held low for a long stretch so that the block's internal queue
   // fills and the input side is stalled.
   initial begin : take_side
      int unsigned stall;
      pixel_result_type seen;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen.pixel_value = rsp_bus.pixel_value;
            seen.repeat_count = rsp_bus.repeat_count;
            seen.column = rsp_bus.column;
            seen.row = rsp_bus.row;
            seen.last_of_image = rsp_bus.last_of_image;
            seen.status = rsp_bus.status;
            sb.check_pixel(seen);
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end else if (stall == 0 && take_idling && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 19);
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Byte values lean toward the all-zero and all-one extremes.
   function automatic logic [BYTE_W-1:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_word(logic cmd, logic [BYTE_W-1:0] b);
      stream_word_type w;
      w.cmd = cmd;
      w.data = b;
      stream_q.push_back(w);
   endfunction

   // Offers one word and waits for it to be taken. The valid line is only
   // lowered when an idle burst starts, so back-to-back words keep it high.
   // The prediction is updated at the accepting edge, ahead of the earliest
   // result it can cause.
   task automatic send_word(stream_word_type w);
      if (send_idling && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= w.cmd;
      req_bus.data_byte <= w.data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.decode_word(w.cmd, w.data);
      if (w.cmd == CMD_DATA) words_sent++;
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) send_word(stream_q[i]);
      stream_q.delete();
   endtask

   // Stops offering words, waits for every predicted result, then lets the
   // pipeline settle so that a header or partial pixel still in flight has
   // been absorbed before the next register write.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all five registers back to back on the register channel. Only
   // called while the block is idle.
   task automatic set_config(logic [BPP_W-1:0] bpp, logic [COORD_W-1:0] w,
                             logic [COORD_W-1:0] h, logic top, logic expand);
      logic [REG_IDX_W-1:0]  idxs[5];
      logic [REG_DATA_W-1:0] vals[5];
      idxs = '{REG_BYTES_PER_PIXEL, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_TOP_ORIGIN,
               REG_EXPAND_1555};
      vals = '{REG_DATA_W'(bpp), w, h, REG_DATA_W'(top), REG_DATA_W'(expand)};
      csr_bus.valid <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_bus.reg_index <= idxs[i];
         csr_bus.wdata <= vals[i];
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         sb.write_register(idxs[i], vals[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Builds one image stream for the current settings. Well-formed images are
   // rows of run and literal packets that exactly fill each row. The broken
   // shapes end the data early, send a packet that runs past the row end,
   // simply stop in the middle of the image, or are plain noise. Very wide or
   // tall images are only partly generated and then ended early.
   task automatic build_image(image_mode_type mode);
      int unsigned bpp_eff;
      int unsigned rows;
      int unsigned cols;
      int unsigned full_rows;
      int unsigned c;
      int unsigned cnt;
      int unsigned span;
      int unsigned cut;
      int unsigned cross_pkt;
      int unsigned pkt;
      bit complete;
      bit run;
      bit crossed;
      stream_q.delete();
      if (mode == MODE_NOISE || sb.width_reg == 0) begin
         repeat ($urandom_range(3, 10))
            add_word(($urandom_range(0, 5) == 0) ? CMD_END : CMD_DATA, rand_byte());
         return;
      end
      bpp_eff = sb.pixel_bytes();
      cols = (sb.width_reg > 300) ? 300 : sb.width_reg;
      full_rows = (sb.height_reg == 0) ? 1 : sb.height_reg;
      rows = (full_rows > 5) ? 5 : full_rows;
      if (sb.width_reg > 64) rows = 1;
      complete = (cols == sb.width_reg) && (rows == full_rows);
      cross_pkt = (mode == MODE_CROSS) ? $urandom_range(0, 5) : 32'hffff_ffff;
      pkt = 0;
      crossed = 1'b0;
      for (int unsigned r = 0; r < rows && !crossed; r++) begin
         c = 0;
         while (c < cols && !crossed) begin
            span = sb.width_reg - c;
            if (pkt == cross_pkt && span < 128) begin
               // Header whose pixel count runs past the end of the row.
               cnt = $urandom_range(span + 1, 128);
               add_word(CMD_DATA, {1'($urandom_range(0, 1)), 7'(cnt - 1)});
               crossed = 1'b1;
            end else begin
               span = cols - c;
               if (span > 128) span = 128;
               cnt = ($urandom_range(0, 2) == 0) ? span : $urandom_range(1, span);
               // Wide rows favor runs to keep the literal byte count down.
               run = (sb.width_reg > 64) ? ($urandom_range(0, 3) != 0)
                                         : 1'($urandom_range(0, 1));
               add_word(CMD_DATA, (run ? RUN_FLAG : 8'h00) | {1'b0, 7'(cnt - 1)});
               repeat ((run ? 1 : cnt) * bpp_eff) add_word(CMD_DATA, rand_byte());
               c += cnt;
               pkt++;
            end
         end
      end
      if (crossed) return;
      if ((mode == MODE_EARLY_END || mode == MODE_CUT) && stream_q.size() > 1) begin
         cut = $urandom_range(1, stream_q.size() - 1);
         while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
      if (mode == MODE_EARLY_END || (!complete && mode != MODE_CUT)) begin
         add_word(CMD_END, rand_byte());
      end else if (mode == MODE_WELL && $urandom_range(0, 3) == 0) begin
         // End marker at the image start: the block should say nothing.
         add_word(CMD_END, rand_byte());
      end
   endtask

   // Main sequence: reset, a directed pass over the special cases, then
   // random phases of settings and images, each closed by a full drain.
   initial begin : stimulus
      logic [BPP_W-1:0]   bpp;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      int unsigned        pick;
      bit                 hold_done;
      image_mode_type     mode;

      sb = new();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= CMD_DATA;
      req_bus.data_byte <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.reg_index <= REG_BYTES_PER_PIXEL;
      csr_bus.wdata <= '0;
      send_idling = 1'b0;
      take_idling = 1'b0;
      long_hold_req = 1'b0;
      words_sent = 0;
      hold_done = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 3-byte pixels, a one-pixel image, bottom origin.
      // An end marker at the image start is ignored; then a full image with
      // extreme bytes, a packet too long for the row, a run that completes
      // the image, and an end marker in the middle of a pixel.
      add_word(CMD_END, 8'h00);
      add_word(CMD_DATA, 8'h00);
      add_word(CMD_DATA, 8'h00);
      add_word(CMD_DATA, 8'hff);
      add_word(CMD_DATA, 8'h80);
      add_word(CMD_DATA, 8'h81);
      add_word(CMD_DATA, 8'h80);
      add_word(CMD_DATA, 8'h12);
      add_word(CMD_DATA, 8'h34);
      add_word(CMD_DATA, 8'h56);
      add_word(CMD_DATA, 8'h00);
      add_word(CMD_DATA, 8'haa);
      add_word(CMD_END, 8'hff);
      send_stream();
      drain();

      // Longest run packet, expanded from 1555 with alpha set, top origin.
      set_config(3'd2, 16'd128, 16'd1, 1'b1, 1'b1);
      add_word(CMD_DATA, 8'hff);
      add_word(CMD_DATA, 8'hff);
      add_word(CMD_DATA, 8'hff);
      send_stream();
      drain();

      // Zero width: any header crosses the row end. Pixel size below range.
      set_config(3'd0, 16'd0, 16'd0, 1'b0, 1'b0);
      add_word(CMD_DATA, 8'h00);
      send_stream();
      drain();

      // Largest image with pixel size above range; the first row lands on
      // row 65534 in bottom-up order. Then the data ends early.
      set_config(3'd7, 16'hffff, 16'hffff, 1'b0, 1'b0);
      add_word(CMD_DATA, 8'h80);
      add_word(CMD_DATA, 8'h01);
      add_word(CMD_DATA, 8'h02);
      add_word(CMD_DATA, 8'h03);
      add_word(CMD_DATA, 8'h04);
      add_word(CMD_END, 8'h00);
      send_stream();
      drain();

      // Zero height: the image completes after its first row, which is
      // numbered 65535 in bottom-up order.
      set_config(3'd3, 16'd2, 16'd0, 1'b0, 1'b0);
      add_word(CMD_DATA, 8'h81);
      add_word(CMD_DATA, 8'h5a);
      add_word(CMD_DATA, 8'ha5);
      add_word(CMD_DATA, 8'h3c);
      send_stream();
      drain();

      // Random phases. Each picks new settings, mostly small images, with
      // rare zero and full-scale sizes, and sends one to three image streams.
      while (words_sent < WORD_GOAL) begin
         send_idling = (words_sent < IDLE_OFF_AT) && ($urandom_range(0, 3) != 0);
         take_idling = (words_sent < IDLE_OFF_AT) && ($urandom_range(0, 3) != 0);

         if (!hold_done && words_sent >= HOLD_AT) begin
            // A long receiver hold while a sizeable image keeps coming in.
            hold_done = 1'b1;
            set_config(3'd3, 16'd24, 16'd6, 1'($urandom_range(0, 1)), 1'b0);
            build_image(MODE_WELL);
            long_hold_req = 1'b1;
            send_stream();
            drain();
            continue;
         end

         bpp = ($urandom_range(0, 7) == 0) ? BPP_W'($urandom_range(0, 7))
                                           : BPP_W'($urandom_range(2, 4));
         pick = $urandom_range(0, 19);
         if (pick == 0) w = 16'd0;
         else if (pick == 1) w = 16'hffff;
         else if (pick < 5) w = COORD_W'($urandom_range(100, 200));
         else w = COORD_W'($urandom_range(1, 24));
         pick = $urandom_range(0, 19);
         if (pick == 0) h = 16'd0;
         else if (pick == 1) h = 16'hffff;
         else h = COORD_W'($urandom_range(1, 5));
         set_config(bpp, w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

         repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) mode = MODE_WELL;
            else if (pick == 6) mode = MODE_EARLY_END;
            else if (pick == 7) mode = MODE_CROSS;
            else if (pick == 8) mode = MODE_CUT;
            else mode = MODE_NOISE;
            build_image(mode);
            send_stream();
         end
         // A stream cut off mid-image leaves the block mid-image, so the next
         // phase also writes its registers in the middle of an image.
         drain();
      end

      drain();
      if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
         $display("tb_tga_rle_pixel_decoder OK");
      end else begin
         $display("tb_tga_rle_pixel_decoder NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/trpd_pkg.sv
rtl/core/trpd_if.sv
rtl/core/trpd_front.sv
rtl/core/trpd_queue.sv
rtl/core/trpd_back.sv
rtl/core/tga_rle_pixel_decoder.sv
rtl/core/trpd_checker.sv
tb/tb_tga_rle_pixel_decoder.sv
